// ===== hdl/scd_pkg.sv =====
// Shared constants, types and helpers for the sine/cosine-in-degrees pipeline.
// Used by sine_cosine_degrees_top and scd_checker; depends on nothing else.
package scd_pkg;

  localparam int SERIES_TERMS = 21;
  localparam int FRAC_BITS = 52;
  localparam int X2_W = 58;

  localparam logic [24:0] FULL_TURN = 25'd23592960;
  // Ninety-two full turns lift any negative angle into the positive range.
  localparam logic [31:0] NEG_OFFSET = 32'd2170552320;
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] DEG_TO_RAD = (PI_Q62 + 64'd22) / 64'd45;

  localparam logic KIND_SIN = 1'b0;
  localparam logic KIND_COS = 1'b1;

  localparam logic signed [41:0] OUT_MAX = 42'sd1073741824;

  typedef struct packed {
    logic            valid;
    logic            kind;
    logic [63:0]     sum;
    logic [63:0]     term;
    logic [X2_W-1:0] x2;
  } scd_lane_t;

  function automatic logic [31:0] turn_sub(input logic [31:0] a, input int unsigned j);
    logic [31:0] m;
    m = 32'(FULL_TURN) << j;
    return (a >= m) ? (a - m) : a;
  endfunction

endpackage

// ===== hdl/sine_cosine_degrees_top.sv =====
// Pipelined sine/cosine of a Q16.16 angle in degrees by Taylor series, Q2.30 result.
// Depends on scd_pkg for constants, the lane type and the turn reduction helper.
//
//   channel  signals                        width     direction
//   in       in_valid, in_ready, kind,      1, 32     into block
//            angle_deg
//   out      out_valid, out_ready, value    1, 32     out of block
//
// One item can be accepted every cycle while the skid register is empty; each series
// term adds five register stages (reciprocal divide and term multiply, each cut
// into 32-bit partial products).
// Reset is synchronous and clears only the valid bits.
// A skid register behind the output register lets one more item finish while the
// output is stalled; the whole pipeline holds while the skid register is full.
module sine_cosine_degrees_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);
  import scd_pkg::*;

  localparam logic SUB_LAST = ((SERIES_TERMS - 1) % 2) == 1;

  logic en;
  logic skid_valid;
  logic signed [31:0] skid_value;

  logic        v1, v2, v3, v4, v5, v6;
  logic        k1, k2, k3, k4, k5, k6;
  logic [31:0] a1, a2, t1, t2, t3;
  logic [24:0] r3;
  logic [56:0] px_lo;
  logic [51:0] px_hi;
  logic [83:0] xs;
  logic [54:0] x5, x6;
  logic [63:0] p_ll;
  logic [54:0] p_lh;
  logic [45:0] p_hh;
  logic [109:0] x2s;
  scd_lane_t   lane_x;
  scd_lane_t   lane_chain [SERIES_TERMS];

  logic        fvalid;
  logic [63:0] fsum, rs;
  logic signed [41:0] vr;
  logic signed [31:0] res;

  assign en = ~skid_valid;
  assign in_ready = en;

  always_comb begin
    t1 = $unsigned(angle_deg) + (angle_deg[31] ? NEG_OFFSET : 32'd0);
    t1 = turn_sub(t1, 7);
    t1 = turn_sub(t1, 6);
    t2 = turn_sub(a1, 5);
    t2 = turn_sub(t2, 4);
    t2 = turn_sub(t2, 3);
    t3 = turn_sub(a2, 2);
    t3 = turn_sub(t3, 1);
    t3 = turn_sub(t3, 0);
    xs = 84'(px_lo) + (84'(px_hi) << 32) + (84'd1 << 27);
    x2s = 110'(p_ll) + (110'(p_lh) << 33) + (110'(p_hh) << 64) + (110'd1 << 51);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      lane_x.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      lane_x.valid <= v6;
    end
    if (en) begin
      k1 <= kind;
      a1 <= t1;
      k2 <= k1;
      a2 <= t2;
      k3 <= k2;
      r3 <= t3[24:0];
      k4 <= k3;
      px_lo <= 57'(r3) * 57'(DEG_TO_RAD[31:0]);
      px_hi <= 52'(r3) * 52'(DEG_TO_RAD[58:32]);
      k5 <= k4;
      x5 <= xs[82:28];
      k6 <= k5;
      x6 <= x5;
      p_ll <= 64'(x5[31:0]) * 64'(x5[31:0]);
      p_lh <= 55'(x5[31:0]) * 55'(x5[54:32]);
      p_hh <= 46'(x5[54:32]) * 46'(x5[54:32]);
      lane_x.kind <= k6;
      lane_x.sum <= 64'd0;
      lane_x.term <= (k6 == KIND_COS) ? (64'd1 << FRAC_BITS) : 64'(x6);
      lane_x.x2 <= x2s[109:52];
    end
  end

  assign lane_chain[0] = lane_x;

  for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
    localparam int D_SIN = (2 * k) * (2 * k + 1);
    localparam int D_COS = (2 * k - 1) * (2 * k);
    localparam logic [63:0] M_SIN = 64'hFFFF_FFFF_FFFF_FFFF / 64'(D_SIN);
    localparam logic [63:0] M_COS = 64'hFFFF_FFFF_FFFF_FFFF / 64'(D_COS);
    localparam logic [127:0] HM_SIN = 128'(D_SIN / 2) * 128'(M_SIN);
    localparam logic [127:0] HM_COS = 128'(D_COS / 2) * 128'(M_COS);
    localparam logic SUB_PREV = ((k - 1) % 2) == 1;

    scd_lane_t    lane_in, l1, l2, l3, l4, l5;
    logic [63:0]  m_sel;
    logic [127:0] hm_sel, qs, ts;
    logic [12:0]  d_sel, h_sel, rem;
    logic [63:0]  pa_ll, pa_lh, pa_hl, pa_hh, q0;
    logic [63:0]  pb_ll, pb_lh, pb_hl, pb_hh;

    assign lane_in = lane_chain[k-1];
    assign lane_chain[k] = l5;

    always_comb begin
      m_sel = (lane_in.kind == KIND_COS) ? M_COS : M_SIN;
      hm_sel = (l1.kind == KIND_COS) ? HM_COS : HM_SIN;
      d_sel = (l2.kind == KIND_COS) ? 13'(D_COS) : 13'(D_SIN);
      h_sel = (l2.kind == KIND_COS) ? 13'(D_COS / 2) : 13'(D_SIN / 2);
      qs = {64'd0, pa_ll} + {32'd0, pa_lh, 32'd0} + {32'd0, pa_hl, 32'd0}
         + {pa_hh, 64'd0} + hm_sel;
      rem = l2.term[12:0] + h_sel - q0[12:0] * d_sel;
      ts = {64'd0, pb_ll} + {32'd0, pb_lh, 32'd0} + {32'd0, pb_hl, 32'd0}
         + {pb_hh, 64'd0} + (128'd1 << (FRAC_BITS - 1));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        l1.valid <= 1'b0;
        l2.valid <= 1'b0;
        l3.valid <= 1'b0;
        l4.valid <= 1'b0;
        l5.valid <= 1'b0;
      end else if (en) begin
        l1.valid <= lane_in.valid;
        l1.kind <= lane_in.kind;
        l1.term <= lane_in.term;
        l1.x2 <= lane_in.x2;
        l1.sum <= SUB_PREV ? (lane_in.sum - lane_in.term) : (lane_in.sum + lane_in.term);
        pa_ll <= 64'(lane_in.term[31:0]) * 64'(m_sel[31:0]);
        pa_lh <= 64'(lane_in.term[31:0]) * 64'(m_sel[63:32]);
        pa_hl <= 64'(lane_in.term[63:32]) * 64'(m_sel[31:0]);
        pa_hh <= 64'(lane_in.term[63:32]) * 64'(m_sel[63:32]);
        l2 <= l1;
        q0 <= qs[127:64];
        l3.valid <= l2.valid;
        l3.kind <= l2.kind;
        l3.sum <= l2.sum;
        l3.x2 <= l2.x2;
        l3.term <= (rem >= d_sel) ? (q0 + 64'd1) : q0;
        l4 <= l3;
        pb_ll <= 64'(l3.term[31:0]) * 64'(l3.x2[31:0]);
        pb_lh <= 64'(l3.term[31:0]) * 64'(l3.x2[X2_W-1:32]);
        pb_hl <= 64'(l3.term[63:32]) * 64'(l3.x2[31:0]);
        pb_hh <= 64'(l3.term[63:32]) * 64'(l3.x2[X2_W-1:32]);
        l5.valid <= l4.valid;
        l5.kind <= l4.kind;
        l5.sum <= l4.sum;
        l5.x2 <= l4.x2;
        l5.term <= ts[115:52];
      end
    end
  end

  always_comb begin
    rs = fsum + (64'd1 << 21);
    vr = $signed(rs[63:22]);
    if (vr > OUT_MAX) begin
      res = 32'sd1073741824;
    end else if (vr < -OUT_MAX) begin
      res = -32'sd1073741824;
    end else begin
      res = vr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (en) begin
      fvalid <= lane_chain[SERIES_TERMS-1].valid;
    end
    if (en) begin
      fsum <= SUB_LAST ? (lane_chain[SERIES_TERMS-1].sum - lane_chain[SERIES_TERMS-1].term)
                       : (lane_chain[SERIES_TERMS-1].sum + lane_chain[SERIES_TERMS-1].term);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fvalid;
      end
    end else if (fvalid && en) begin
      skid_valid <= 1'b1;
    end
    if (!out_valid || out_ready) begin
      value <= skid_valid ? skid_value : res;
    end else if (en) begin
      skid_value <= res;
    end
  end

endmodule

// ===== hdl/scd_checker.sv =====
// Port-level checks for sine_cosine_degrees_top, attached by the bind below.
// Depends on scd_pkg for the output limit.
module scd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] value
);
  import scd_pkg::*;

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= OUT_MAX && value >= -OUT_MAX))
    else $error("Result is outside the unit range.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("Stalled result changed.");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input is blocked with no result waiting.");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready)
    else $error("Input reopened while the output stays stalled.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind sine_cosine_degrees_top scd_checker u_scd_checker (.*);

// ===== bench/sine_cosine_degrees_top_test.sv =====
// Testbench for sine_cosine_degrees_top: random and directed angles with a scoreboard.
// Depends on scd_pkg and sine_cosine_degrees_top; predicts each sine or cosine itself.
`timescale 1ns / 1ps

module sine_cosine_degrees_top_test;
  import scd_pkg::*;

  localparam logic [63:0] RAD_PER_DEG = (64'hC90F_DAA2_2168_C235 + 64'd22) / 64'd45;
  localparam longint TURN_Q16 = 64'sd23592960;
  localparam longint CYCLE_LIMIT = 64'sd2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_SIN;
  logic signed [31:0] angle_deg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] value;

  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  sine_cosine_degrees_top dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] taylor_deg(input logic knd, input logic signed [31:0] ang);
    longint r;
    logic [127:0] p;
    logic [63:0] x, x2, term, sum, q, d, n, biased;
    longint v;
    r = longint'(ang) % TURN_Q16;
    if (r < 0) r += TURN_Q16;
    p = 128'(r) * 128'(RAD_PER_DEG) + (128'd1 << 27);
    x = 64'(p >> 28);
    p = 128'(x) * 128'(x) + (128'd1 << 51);
    x2 = 64'(p >> 52);
    term = (knd == KIND_COS) ? (64'd1 << 52) : x;
    sum = term;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      n = 64'(2 * k);
      d = (knd == KIND_COS) ? (n - 64'd1) * n : n * (n + 64'd1);
      q = (term + d / 64'd2) / d;
      p = 128'(q) * 128'(x2) + (128'd1 << 51);
      term = 64'(p >> 52);
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    biased = (sum + (64'd1 << 21)) ^ 64'h8000_0000_0000_0000;
    v = longint'(biased >> 22) - (64'sd1 << 41);
    if (v > 64'sd1073741824) v = 64'sd1073741824;
    if (v < -64'sd1073741824) v = -64'sd1073741824;
    return v[31:0];
  endfunction

  class trig_scoreboard;
    logic [31:0] pending_values[$];
    int errors = 0;

    task report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
      errors++;
    endtask

    function void note_angle(input logic knd, input logic signed [31:0] ang);
      pending_values.push_back(taylor_deg(knd, ang));
    endfunction

    task check_value(input logic [31:0] got);
      logic [31:0] want;
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value %h", got));
      end else begin
        want = pending_values.pop_front();
        if (got !== want) report_mismatch($sformatf("value %h, predicted %h", got, want));
      end
    endtask
  endclass

  trig_scoreboard sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_value(value);
  end

  task send_angle(input logic knd, input logic signed [31:0] ang);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= knd;
    angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    sb.note_angle(knd, ang);
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk);
  endtask

  task send_random(input int count);
    logic signed [31:0] ang;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: ang = $signed($urandom());
        1: ang = $signed($urandom_range(94371840)) - 32'sd47185920;
        2: ang = 32'(($urandom_range(16) - 8) * 45) <<< 16;
        default: ang = ($signed($urandom_range(720)) - 32'sd360) <<< 16;
      endcase
      send_angle(logic'($urandom_range(1)), ang);
    end
  endtask

  initial begin
    logic signed [31:0] directed[$];
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sd90 <<< 16, 32'sd180 <<< 16, 32'sd270 <<< 16, 32'sd360 <<< 16,
                 -(32'sd90 <<< 16), -(32'sd360 <<< 16), 32'sd23592959};
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_angle(KIND_SIN, directed[i]);
      send_angle(KIND_COS, directed[i]);
    end
    wait_drained();
    send_random(400);
    idle_pct = 85;
    send_random(300);
    wait_drained();
    idle_pct = 0;
    stall_pct = 85;
    send_random(400);
    idle_pct = 27;
    stall_pct = 27;
    send_random(400);
    wait_drained();
    stall_pct = 0;
    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
